[sv/todat_pkg.sv]
package todat_pkg;

  // Day length and field widths
  localparam int DAY_TICKS   = 24 * 60 * 60;
  localparam int HAND_W      = 17;
  localparam int VALUE_W     = 32;
  localparam int SLOT_W      = 3;
  localparam int MASK_W      = 8;
  localparam int REQ_W       = 3;
  localparam int ALARM_SLOTS = 8;

  // Value reduction: 86400 = 675 * 2^7, so the low 7 bits pass straight through
  // and the upper bits are reduced modulo 675 by reciprocal multiplication
  localparam int LOW_W       = 7;
  localparam int HIGH_W      = VALUE_W - LOW_W;
  localparam int DAY_ODD     = DAY_TICKS >> LOW_W;
  localparam int ODD_W       = 10;
  localparam int RECIP_SHIFT = HIGH_W + ODD_W;
  localparam int RECIP_W     = 26;
  localparam int QUOT_W      = HIGH_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] DAY_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

  localparam logic [HAND_W-1:0] LAST_TICK = HAND_W'(DAY_TICKS - 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 3'd0,
    REQ_SET_TIME  = 3'd1,
    REQ_CONFIGURE = 3'd2,
    REQ_RESTART   = 3'd3,
    REQ_STOP      = 3'd4,
    REQ_POLL      = 3'd5
  } req_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture a new request
    logic execute;  // apply request to state and write the result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic operand_ready;  // reduced value available (or not needed)
    logic out_free;       // result register can take a new result
  } dp_status_t;

  // Requests that carry a time value
  function automatic logic needs_value(input logic [REQ_W-1:0] req);
    logic r;
    r = (req == REQ_SET_TIME) || (req == REQ_CONFIGURE) || (req == REQ_RESTART);
    return r;
  endfunction

endpackage

[sv/todat_reduce.sv]
module todat_reduce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [todat_pkg::VALUE_W-1:0] value_in,
  output logic                          done,
  output logic [todat_pkg::HAND_W-1:0]  remainder
);
  import todat_pkg::*;

  logic [LOW_W-1:0]          low_bits;
  logic [HIGH_W-1:0]         high_bits;
  logic [QUOT_W-1:0]         quot;
  logic [ODD_W-1:0]          odd_rem;
  logic                      quot_pend;
  logic                      rem_pend;
  logic [HIGH_W+RECIP_W-1:0] prod;
  logic [HIGH_W-1:0]         back;

  // Quotient of the upper bits by 675, exact for every 25-bit operand
  assign prod = (HIGH_W+RECIP_W)'(high_bits) * (HIGH_W+RECIP_W)'(DAY_RECIP);

  // Whole multiple of 675 to take off the upper bits
  assign back = HIGH_W'(quot) * HIGH_W'(DAY_ODD);

  // Stage tracking: start sets quot_pend, which then sets rem_pend
  always_ff @(posedge clk) begin
    if (rst) begin
      quot_pend <= 1'b0;
      rem_pend  <= 1'b0;
    end else begin
      quot_pend <= start;
      rem_pend  <= quot_pend;
    end
  end

  // Operand split, quotient and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      low_bits  <= value_in[LOW_W-1:0];
      high_bits <= value_in[VALUE_W-1:LOW_W];
    end
    if (quot_pend) begin
      quot <= prod[HIGH_W+RECIP_W-1:RECIP_SHIFT];
    end
    if (rem_pend) begin
      odd_rem <= ODD_W'(high_bits - back);
    end
  end

  assign done      = !quot_pend && !rem_pend;
  assign remainder = {odd_rem, low_bits};

endmodule

[sv/todat_ctrl.sv]
module todat_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  todat_pkg::dp_status_t   status,
  output todat_pkg::dp_cmd_t      cmd
);
  import todat_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_BUSY;
      end
      ST_BUSY: begin
        if (status.operand_ready && status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_BUSY: begin
        cmd.execute = status.operand_ready && status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[sv/todat_dp.sv]
module todat_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  todat_pkg::dp_cmd_t            cmd,
  output todat_pkg::dp_status_t         status,
  input  logic [todat_pkg::REQ_W-1:0]   req_type,
  input  logic [todat_pkg::SLOT_W-1:0]  slot,
  input  logic [todat_pkg::VALUE_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [todat_pkg::HAND_W-1:0]  hand,
  output logic [todat_pkg::MASK_W-1:0]  fired_mask,
  output logic                          timed_out
);
  import todat_pkg::*;

  // Captured request
  logic [REQ_W-1:0]  req_r;
  logic [SLOT_W-1:0] slot_r;

  // Architectural state
  logic [HAND_W-1:0]      day_hand;
  logic [HAND_W-1:0]      alarm_time [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] alarm_armed;
  logic [ALARM_SLOTS-1:0] timeout_flag;

  logic                          red_done;
  logic [HAND_W-1:0]             red_value;
  logic [HAND_W-1:0]             tick_hand;
  logic [HAND_W-1:0]             hand_next;
  logic [ALARM_SLOTS-1:0]        sel;
  logic [ALARM_SLOTS-1:0]        hit;
  logic [ALARM_SLOTS+MASK_W-1:0] hit_ext;
  logic [MASK_W-1:0]             fired_next;
  logic                          polled;
  logic                          is_tick;

  todat_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .value_in (value),
    .done     (red_done),
    .remainder(red_value)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_type;
      slot_r <= slot;
    end
  end

  assign status.operand_ready = !needs_value(req_r) || red_done;
  assign status.out_free      = !out_valid || out_ready;

  // Hand advance with wrap at end of day
  assign tick_hand = (day_hand == LAST_TICK) ? '0 : day_hand + 1'b1;
  assign is_tick   = (req_r == REQ_TICK);

  // Slot decode, alarm match and poll read
  always_comb begin
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      sel[i] = (32'(slot_r) == i);
      hit[i] = alarm_armed[i] && (alarm_time[i] == tick_hand);
    end
    polled = |(sel & timeout_flag);
  end

  assign hit_ext    = {{MASK_W{1'b0}}, hit};
  assign fired_next = is_tick ? hit_ext[MASK_W-1:0] : '0;
  assign hand_next  = is_tick ? tick_hand :
                      (req_r == REQ_SET_TIME) ? red_value : day_hand;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      day_hand     <= '0;
      alarm_armed  <= '0;
      timeout_flag <= '0;
    end else if (cmd.execute) begin
      day_hand <= hand_next;
      case (req_r)
        REQ_TICK: begin
          timeout_flag <= timeout_flag | hit;
        end
        REQ_CONFIGURE: begin
          alarm_armed  <= alarm_armed | sel;
          timeout_flag <= timeout_flag & ~sel;
        end
        REQ_RESTART: begin
          alarm_armed <= alarm_armed | sel;
        end
        REQ_STOP: begin
          alarm_armed <= alarm_armed & ~sel;
        end
        REQ_POLL: begin
          timeout_flag <= timeout_flag & ~sel;
        end
        default: begin
          alarm_armed <= alarm_armed;
        end
      endcase
    end
  end

  // Alarm times, written by configure and restart
  always_ff @(posedge clk) begin
    if (cmd.execute && ((req_r == REQ_CONFIGURE) || (req_r == REQ_RESTART))) begin
      for (int i = 0; i < ALARM_SLOTS; i++) begin
        if (sel[i]) alarm_time[i] <= red_value;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      hand       <= hand_next;
      fired_mask <= fired_next;
      timed_out  <= (req_r == REQ_POLL) && polled;
    end
  end

endmodule

[sv/time_of_day_alarm_table.sv]
// Channel  | Signals                            | Direction
// request  | in_valid, in_ready, req_type,      | in
//          | slot, value                        |
// result   | out_valid, out_ready, hand,        | out
//          | fired_mask, timed_out              |
//
// One request in flight at a time; each request gives one result.
// Tick, stop, poll and unused codes are applied once the result register is free.
// Set time, configure and restart also wait for the value to be reduced modulo
// 86400 by a two-stage reciprocal-multiply remainder unit.
// A new request is accepted while the previous result waits in the output
// register; a stalled result holds the next request before it is applied.
// Synchronous reset: internal hand 0, all slots disarmed, all flags clear.
module time_of_day_alarm_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [todat_pkg::REQ_W-1:0]   req_type,
  input  logic [todat_pkg::SLOT_W-1:0]  slot,
  input  logic [todat_pkg::VALUE_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [todat_pkg::HAND_W-1:0]  hand,
  output logic [todat_pkg::MASK_W-1:0]  fired_mask,
  output logic                          timed_out
);
  import todat_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  todat_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  todat_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_type  (req_type),
    .slot      (slot),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hand      (hand),
    .fired_mask(fired_mask),
    .timed_out (timed_out)
  );

endmodule
